FILE: rtl/irs_pkg.sv
package irs_pkg;

    localparam int ADC_W     = 10;
    localparam int CNT_W     = 16;
    localparam int ID_W      = 2;
    localparam int CM_W      = 8;
    localparam int NUM_W     = 32;
    localparam int QUO_BITS  = 8;
    localparam int DVS_W     = 36;
    localparam int STEP_W    = $clog2(ADC_W);

    localparam int NUM_SENSORS_DEFAULT = 3;

    localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd50;
    localparam logic [ADC_W-1:0] FAR_LIMIT    = 10'd60;
    localparam logic [ADC_W-1:0] NEAR_LIMIT   = 10'd600;
    localparam logic [CM_W-1:0]  FAR_CM       = 8'd200;
    localparam logic [CM_W-1:0]  NEAR_CM      = 8'd0;

    // Numerator is 175 * (16135808 - 12393 * v), denominator 884 * (619 * v - 800).
    localparam logic [NUM_W-1:0] NUM_K = 32'd2823766400;
    localparam logic [NUM_W-1:0] NUM_M = 32'd2168775;
    localparam logic [DVS_W-1:0] DEN_M = 36'd547196;
    localparam logic [DVS_W-1:0] DEN_K = 36'd707200;

    localparam logic [DVS_W-1:0] DADD_INIT = DEN_M << (QUO_BITS - 1);
    localparam logic [DVS_W-1:0] DVS_INIT  = DVS_W'(0) - (DEN_K << (QUO_BITS - 1));

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

endpackage

FILE: rtl/irs_in_if.sv
interface irs_in_if
    import irs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

FILE: rtl/irs_out_if.sv
interface irs_out_if
    import irs_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            measured;
    logic [ID_W-1:0] sensor_id;
    logic [CM_W-1:0] distance_cm;
    logic [ID_W-1:0] next_sensor;

    modport source (output valid, output measured, output sensor_id, output distance_cm,
                    output next_sensor, input ready);
    modport sink (input valid, input measured, input sensor_id, input distance_cm,
                  input next_sensor, output ready);
endinterface

FILE: rtl/infrared_range_scanner.sv
// Timing: a tick without a measurement, or with a sample outside 60..600, goes straight
// into the result register on acceptance; one in that band takes 10 bit-serial multiply
// steps, 8 restoring divide steps and one load into the result register, once it is free.
// Throughput: one tick per cycle while the result register is empty or being read out;
// a measurement in the band holds the input off until its result has been loaded.
// Reset (synchronous, active low): period and countdown 50, sensor 0, no result.
module infrared_range_scanner
    import irs_pkg::*;
#(
    parameter int NUM_SENSORS = NUM_SENSORS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    irs_in_if.sink           i_in,
    irs_out_if.source        o_out
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_period, n_period;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ID_W-1:0]     r_sensor, n_sensor;
    logic [ID_W-1:0]     r_id, n_id;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [ADC_W-1:0]    r_sample, n_sample;
    logic [NUM_W-1:0]    r_num, n_num;
    logic [NUM_W-1:0]    r_madd, n_madd;
    logic [DVS_W-1:0]    r_dvs, n_dvs;
    logic [DVS_W-1:0]    r_dadd, n_dadd;
    logic [QUO_BITS-1:0] r_quo, n_quo;
    logic                r_ov, n_ov;
    logic                r_meas, n_meas;
    logic [ID_W-1:0]     r_oid, n_oid;
    logic [CM_W-1:0]     r_dist, n_dist;
    logic [ID_W-1:0]     r_next, n_next;

    logic                w_slot_free;
    logic                w_accept;
    logic [CNT_W-1:0]    w_dec;
    logic [ID_W-1:0]     w_adv;
    logic                w_ge;

    assign w_slot_free = !r_ov || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_dec       = r_cnt - CNT_W'(1);
    assign w_adv       = (r_sensor == ID_W'(NUM_SENSORS - 1)) ? '0 : r_sensor + ID_W'(1);
    assign w_ge        = {{(DVS_W - NUM_W){1'b0}}, r_num} >= r_dvs;

    always_comb begin
        n_state  = r_state;
        n_period = i_cfg_we ? i_cfg_data : r_period;
        n_cnt    = r_cnt;
        n_sensor = r_sensor;
        n_id     = r_id;
        n_step   = r_step;
        n_sample = r_sample;
        n_num    = r_num;
        n_madd   = r_madd;
        n_dvs    = r_dvs;
        n_dadd   = r_dadd;
        n_quo    = r_quo;
        n_ov     = r_ov && !o_out.ready;
        n_meas   = r_meas;
        n_oid    = r_oid;
        n_dist   = r_dist;
        n_next   = r_next;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_dec != '0) begin
                        n_cnt  = w_dec;
                        n_ov   = 1'b1;
                        n_meas = 1'b0;
                        n_oid  = '0;
                        n_dist = '0;
                        n_next = r_sensor;
                    end else begin
                        n_cnt    = r_period;
                        n_sensor = w_adv;
                        n_id     = r_sensor;
                        if (!(i_in.adc_sample inside {[FAR_LIMIT:NEAR_LIMIT]})) begin
                            n_ov   = 1'b1;
                            n_meas = 1'b1;
                            n_oid  = r_sensor;
                            n_dist = (i_in.adc_sample < FAR_LIMIT) ? FAR_CM : NEAR_CM;
                            n_next = w_adv;
                        end else begin
                            n_state  = S_MUL;
                            n_step   = '0;
                            n_sample = i_in.adc_sample;
                            n_num    = NUM_K;
                            n_madd   = NUM_M;
                            n_dvs    = DVS_INIT;
                            n_dadd   = DADD_INIT;
                        end
                    end
                end
            end
            S_MUL: begin
                // Sample bits enter LSB first against left-shifting constant multiples.
                if (r_sample[0]) begin
                    n_num = r_num - r_madd;
                    n_dvs = r_dvs + r_dadd;
                end
                n_sample = r_sample >> 1;
                n_madd   = r_madd << 1;
                n_dadd   = r_dadd << 1;
                if (r_step == STEP_W'(ADC_W - 1)) begin
                    n_state = S_DIV;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DIV: begin
                // The quotient stays below 2**QUO_BITS, so only that many steps are needed.
                if (w_ge) begin
                    n_num = r_num - r_dvs[NUM_W-1:0];
                end
                n_quo = {r_quo[QUO_BITS-2:0], w_ge};
                n_dvs = r_dvs >> 1;
                if (r_step == STEP_W'(QUO_BITS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                    n_ov    = 1'b1;
                    n_meas  = 1'b1;
                    n_oid   = r_id;
                    n_dist  = r_quo[CM_W-1:0];
                    n_next  = r_sensor;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_period <= PERIOD_RESET;
            r_cnt    <= PERIOD_RESET;
            r_sensor <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_period <= n_period;
            r_cnt    <= n_cnt;
            r_sensor <= n_sensor;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_step   <= n_step;
        r_sample <= n_sample;
        r_num    <= n_num;
        r_madd   <= n_madd;
        r_dvs    <= n_dvs;
        r_dadd   <= n_dadd;
        r_quo    <= n_quo;
        r_meas   <= n_meas;
        r_oid    <= n_oid;
        r_dist   <= n_dist;
        r_next   <= n_next;
    end

    assign o_out.valid       = r_ov;
    assign o_out.measured    = r_meas;
    assign o_out.sensor_id   = r_oid;
    assign o_out.distance_cm = r_dist;
    assign o_out.next_sensor = r_next;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input taken while a conversion is running");

    a_dist_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_meas) |-> (r_dist <= FAR_CM))
        else $error("distance above the far limit");

    a_idle_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_meas) |-> (r_oid == '0 && r_dist == '0))
        else $error("tick without measurement carries data");

    a_expiry_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_cnt == CNT_W'(1)) |=> (r_ov || r_state == S_MUL))
        else $error("countdown expiry did not start a measurement");

    a_sensor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sensor <= ID_W'(NUM_SENSORS - 1))
        else $error("sensor index out of range");

endmodule
